/* hw/rtl/wft_pkg.sv */
`default_nettype none
package wft_pkg;
   localparam int MaxWords  = 256;
   localparam int MaxLen    = 32;
   localparam int CountBits = 16;
   localparam int SlotBits  = $clog2(MaxWords);
   localparam int PosBits   = $clog2(MaxLen);
   localparam int LenBits   = $clog2(MaxLen + 1);
   localparam int UsedBits  = $clog2(MaxWords + 1);
   localparam int CharAddrBits = SlotBits + PosBits;

   localparam logic [1:0] CMD_BYTE  = 2'd0;
   localparam logic [1:0] CMD_END   = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;
   localparam logic [1:0] CMD_CLEAR = 2'd3;

   localparam logic [1:0] ERR_NONE = 2'd0;
   localparam logic [1:0] ERR_FULL = 2'd1;
   localparam logic [1:0] ERR_LONG = 2'd2;

   localparam logic [CountBits-1:0] CountMax = '1;

   function automatic logic [7:0] fold_case(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c >= 8'd65 && c <= 8'd90) begin
         r = c + 8'd32;
      end
      return r;
   endfunction
endpackage
`default_nettype wire

/* hw/rtl/word_frequency_table.sv */
`default_nettype none
// Flow: a byte that extends a word, a separator with nothing pending or a clear goes
// straight to the output state; a read passes ST_READ and ST_RWAIT first. A word end walks
// the used slots in the shared compare unit (ST_SLOT, ST_LWAIT, then ST_CHAR and ST_CWAIT
// per equal character); a new word is then checked for room and copied in by ST_COPY, and
// the result leaves through ST_OUT. One item at a time: the next item is accepted only after
// the result leaves. Reset (synchronous) empties table and pending word; key_count is 3.
module word_frequency_table
   import wft_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_cmd,
   input  wire logic [7:0]  req_text_byte,
   input  wire logic [7:0]  req_entry_index,
   input  wire logic [4:0]  req_char_pos,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_word_done,
   output logic             rsp_word_new,
   output logic [7:0]       rsp_word_slot,
   output logic [15:0]      rsp_word_count,
   output logic [1:0]       rsp_error_code,
   output logic [7:0]       rsp_read_char,
   output logic [5:0]       rsp_read_len,
   output logic [15:0]      rsp_read_count,
   output logic             rsp_read_selected,
   output logic [8:0]       rsp_entries_used,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [15:0] csr_key_count
);
   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_SLOT  = 9'b000000010,
      ST_LWAIT = 9'b000000100,
      ST_CHAR  = 9'b000001000,
      ST_CWAIT = 9'b000010000,
      ST_COPY  = 9'b000100000,
      ST_READ  = 9'b001000000,
      ST_RWAIT = 9'b010000000,
      ST_OUT   = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   logic [7:0]           chars_mem [MaxWords*MaxLen];
   logic [LenBits-1:0]   len_mem   [MaxWords];
   logic [CountBits-1:0] cnt_mem   [MaxWords];
   logic [7:0]           pend_mem  [MaxLen];

   logic [UsedBits-1:0]  used_ff;
   logic [LenBits-1:0]   plen_ff;
   logic                 povf_ff;
   logic [15:0]          key_ff;
   logic [UsedBits-1:0]  slot_ff;
   logic [LenBits-1:0]   pos_ff;
   logic [1:0]           cmd_ff;
   logic [7:0]           idx_ff;
   logic [PosBits-1:0]   rpos_ff;

   logic [7:0]           rd_char_q;
   logic [LenBits-1:0]   rd_len_q;
   logic [CountBits-1:0] rd_cnt_q;
   logic [7:0]           rd_pend_q;

   logic                 o_done_ff, o_new_ff, o_sel_ff;
   logic [7:0]           o_slot_ff, o_rchar_ff;
   logic [15:0]          o_cnt_ff, o_rcnt_ff;
   logic [1:0]           o_err_ff;
   logic [5:0]           o_rlen_ff;

   logic [SlotBits-1:0]  slot_a;
   logic [PosBits-1:0]   pos_a;
   logic [SlotBits-1:0]  rd_slot;
   logic [PosBits-1:0]   rd_pos;
   logic                 take;
   logic                 is_sep;
   logic                 chars_we, meta_we;
   logic [CountBits-1:0] meta_cnt;
   logic [LenBits-1:0]   pos_prev;

   assign slot_a  = slot_ff[SlotBits-1:0];
   assign pos_a   = pos_ff[PosBits-1:0];
   assign pos_prev = pos_ff - 1'b1;
   assign take    = req_valid && !req_stall;
   assign is_sep  = (req_text_byte == 8'd32) || (req_text_byte == 8'd10) ||
                    (req_text_byte == 8'd0);
   assign req_stall = (state_ff != ST_IDLE) || rsp_valid;
   assign csr_ready = 1'b1;

   // Table read port: slot walk during search, requested slot during read.
   always_comb begin
      rd_slot = slot_a;
      rd_pos  = pos_a;
      if (state_ff == ST_READ) begin
         rd_slot = idx_ff[SlotBits-1:0];
         rd_pos  = rpos_ff;
      end
   end

   always_ff @(posedge clock) begin
      rd_char_q <= chars_mem[{rd_slot, rd_pos}];
      rd_len_q  <= len_mem[rd_slot];
      rd_cnt_q  <= cnt_mem[rd_slot];
      rd_pend_q <= pend_mem[pos_a];
      if (chars_we) begin
         chars_mem[{slot_a, pos_prev[PosBits-1:0]}] <= rd_pend_q;
      end
      if (meta_we) begin
         len_mem[slot_a] <= plen_ff;
         cnt_mem[slot_a] <= meta_cnt;
      end
      if (take && req_cmd == CMD_BYTE && !is_sep && plen_ff < LenBits'(MaxLen)) begin
         pend_mem[plen_ff[PosBits-1:0]] <= req_text_byte;
      end
   end

   always_comb begin
      state_in = state_ff;
      chars_we = 1'b0;
      meta_we  = 1'b0;
      meta_cnt = rd_cnt_q;
      unique case (state_ff)
         ST_IDLE: begin
            if (take) begin
               priority if (req_cmd == CMD_READ) begin
                  state_in = ST_READ;
               end else if ((req_cmd == CMD_END || (req_cmd == CMD_BYTE && is_sep)) &&
                            (plen_ff != '0 || povf_ff)) begin
                  state_in = povf_ff ? ST_OUT : ST_SLOT;
               end else begin
                  state_in = ST_OUT;
               end
            end
         end
         ST_SLOT: begin
            if (slot_ff == used_ff) begin
               state_in = (used_ff == UsedBits'(MaxWords)) ? ST_OUT : ST_COPY;
            end else begin
               state_in = ST_LWAIT;
            end
         end
         ST_LWAIT: state_in = ST_CHAR;
         ST_CHAR: begin
            // rd_len_q holds the length of slot_ff; rd_char_q at pos_ff is compared in ST_CWAIT
            if (rd_len_q != plen_ff) begin
               state_in = ST_SLOT;
            end else if (pos_ff == plen_ff) begin
               meta_we  = 1'b1;
               meta_cnt = (rd_cnt_q == CountMax) ? rd_cnt_q : rd_cnt_q + 1'b1;
               state_in = ST_OUT;
            end else begin
               state_in = ST_CWAIT;
            end
         end
         ST_CWAIT: begin
            if (fold_case(rd_char_q) != fold_case(rd_pend_q)) begin
               state_in = ST_SLOT;
            end else begin
               state_in = ST_CHAR;
            end
         end
         ST_COPY: begin
            if (pos_ff != '0) begin
               chars_we = 1'b1;
            end
            if (pos_ff == plen_ff) begin
               meta_we  = 1'b1;
               meta_cnt = CountBits'(1);
               state_in = ST_OUT;
            end
         end
         ST_READ:  state_in = ST_RWAIT;
         ST_RWAIT: state_in = ST_OUT;
         ST_OUT:   state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         used_ff   <= '0;
         plen_ff   <= '0;
         povf_ff   <= 1'b0;
         key_ff    <= 16'd3;
         rsp_valid <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            key_ff <= csr_key_count;
         end
         if (rsp_valid && !rsp_stall) begin
            rsp_valid <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (take) begin
                  cmd_ff    <= req_cmd;
                  idx_ff    <= req_entry_index;
                  rpos_ff   <= req_char_pos[PosBits-1:0];
                  slot_ff   <= '0;
                  pos_ff    <= '0;
                  o_done_ff <= 1'b0;
                  o_new_ff  <= 1'b0;
                  o_slot_ff <= '0;
                  o_cnt_ff  <= '0;
                  o_err_ff  <= ERR_NONE;
                  o_rchar_ff <= '0;
                  o_rlen_ff <= '0;
                  o_rcnt_ff <= '0;
                  o_sel_ff  <= 1'b0;
                  if (req_cmd == CMD_CLEAR) begin
                     used_ff <= '0;
                  end
                  if (req_cmd == CMD_BYTE && !is_sep) begin
                     if (plen_ff < LenBits'(MaxLen)) begin
                        plen_ff <= plen_ff + 1'b1;
                     end else begin
                        povf_ff <= 1'b1;
                     end
                  end
                  if ((req_cmd == CMD_END || (req_cmd == CMD_BYTE && is_sep)) &&
                      (plen_ff != '0 || povf_ff)) begin
                     o_done_ff <= 1'b1;
                     if (povf_ff) begin
                        o_err_ff <= ERR_LONG;
                        plen_ff  <= '0;
                        povf_ff  <= 1'b0;
                     end
                  end
               end
            end
            ST_SLOT: begin
               pos_ff <= '0;
               if (slot_ff == used_ff && used_ff == UsedBits'(MaxWords)) begin
                  o_err_ff <= ERR_FULL;
                  plen_ff  <= '0;
               end
            end
            ST_CHAR: begin
               if (rd_len_q != plen_ff) begin
                  slot_ff <= slot_ff + 1'b1;
               end else if (pos_ff == plen_ff) begin
                  o_slot_ff <= 8'(slot_ff);
                  o_cnt_ff  <= 16'(meta_cnt);
                  plen_ff   <= '0;
               end
            end
            ST_CWAIT: begin
               if (fold_case(rd_char_q) != fold_case(rd_pend_q)) begin
                  slot_ff <= slot_ff + 1'b1;
               end else begin
                  pos_ff <= pos_ff + 1'b1;
               end
            end
            ST_COPY: begin
               // pending byte at pos_ff arrives next cycle; write trails by one
               if (pos_ff != plen_ff) begin
                  pos_ff <= pos_ff + 1'b1;
               end else begin
                  used_ff   <= used_ff + 1'b1;
                  o_new_ff  <= 1'b1;
                  o_slot_ff <= 8'(slot_ff);
                  o_cnt_ff  <= 16'd1;
                  plen_ff   <= '0;
               end
            end
            ST_RWAIT: begin
               if (UsedBits'(idx_ff) < used_ff) begin
                  o_rchar_ff <= (LenBits'(rpos_ff) < rd_len_q) ? rd_char_q : 8'd0;
                  o_rlen_ff  <= 6'(rd_len_q);
                  o_rcnt_ff  <= 16'(rd_cnt_q);
                  o_sel_ff   <= (16'(rd_cnt_q) == key_ff);
               end
            end
            ST_OUT: rsp_valid <= 1'b1;
            default: ;
         endcase
      end
   end

   assign rsp_word_done     = o_done_ff;
   assign rsp_word_new      = o_new_ff;
   assign rsp_word_slot     = o_slot_ff;
   assign rsp_word_count    = o_cnt_ff;
   assign rsp_error_code    = o_err_ff;
   assign rsp_read_char     = o_rchar_ff;
   assign rsp_read_len      = o_rlen_ff;
   assign rsp_read_count    = o_rcnt_ff;
   assign rsp_read_selected = o_sel_ff;
   assign rsp_entries_used  = 9'(used_ff);

   logic unused_cmd;
   assign unused_cmd = ^cmd_ff ^ ^pos_prev;

   assert property (@(posedge clock) disable iff (reset) used_ff <= UsedBits'(MaxWords))
      else $error("used count beyond table size");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> req_stall)
      else $error("ready while busy");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("result dropped while stalled");
   assert property (@(posedge clock) disable iff (reset)
      plen_ff <= LenBits'(MaxLen))
      else $error("pending length overflow");
endmodule
`default_nettype wire

/* dv/testbench.sv */
module testbench;
   import wft_pkg::*;

   localparam int WatchLimit = 100000;

   typedef struct packed {
      logic        done;
      logic        is_new;
      logic [7:0]  slot;
      logic [15:0] count;
      logic [1:0]  err;
      logic [7:0]  rd_char;
      logic [5:0]  rd_len;
      logic [15:0] rd_count;
      logic        rd_sel;
      logic [8:0]  used;
   } word_result_t;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic [1:0]  req_cmd = CMD_BYTE;
   logic [7:0]  req_text_byte = 0;
   logic [7:0]  req_entry_index = 0;
   logic [4:0]  req_char_pos = 0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic        rsp_word_done, rsp_word_new, rsp_read_selected;
   logic [7:0]  rsp_word_slot, rsp_read_char;
   logic [15:0] rsp_word_count, rsp_read_count;
   logic [1:0]  rsp_error_code;
   logic [5:0]  rsp_read_len;
   logic [8:0]  rsp_entries_used;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [15:0] csr_key_count = 0;

   word_frequency_table DUT (.*);

   always #5 clock = ~clock;

   // mirror of the table
   logic [7:0]  tbl_chars [MaxWords][MaxLen];
   int          tbl_len [MaxWords];
   int          tbl_cnt [MaxWords];
   int          n_used;
   logic [7:0]  pend_chars [MaxLen];
   int          pend_len;
   bit          pend_ovf;
   int          key_val;

   word_result_t expected_results[$];
   int          errors = 0;
   int          tx_idle_pct = 0;
   int          rx_idle_pct = 0;
   int          hold_goal = 0;
   int          hold_seen = 0;
   int          hold_left = 0;
   int          quiet_cycles = 0;

   function automatic logic [7:0] lower(input logic [7:0] c);
      return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
   endfunction

   function automatic bool_match(input int s);
      int i;
      if (tbl_len[s] != pend_len) return 0;
      for (i = 0; i < pend_len; i++)
         if (lower(tbl_chars[s][i]) != lower(pend_chars[i])) return 0;
      return 1;
   endfunction

   function automatic void close_word(inout word_result_t r);
      int k;
      int i;
      if (pend_len == 0 && !pend_ovf) return;
      r.done = 1;
      if (pend_ovf) begin
         r.err = ERR_LONG;
      end else begin
         for (k = 0; k < n_used; k++) begin
            if (bool_match(k)) break;
         end
         if (k < n_used) begin
            if (tbl_cnt[k] < 65535) tbl_cnt[k]++;
            r.slot = k[7:0];
            r.count = tbl_cnt[k][15:0];
         end else if (n_used >= MaxWords) begin
            r.err = ERR_FULL;
         end else begin
            for (i = 0; i < pend_len; i++) tbl_chars[k][i] = pend_chars[i];
            tbl_len[k] = pend_len;
            tbl_cnt[k] = 1;
            n_used++;
            r.is_new = 1;
            r.slot = k[7:0];
            r.count = 1;
         end
      end
      pend_len = 0;
      pend_ovf = 0;
   endfunction

   function automatic word_result_t predict_table(input logic [1:0] cmd, input logic [7:0] ch,
                                                  input logic [7:0] idx, input logic [4:0] pos);
      word_result_t r;
      r = '0;
      case (cmd)
         CMD_BYTE: begin
            if (ch == " " || ch == 8'h0a || ch == 8'h00) begin
               close_word(r);
            end else if (pend_len < MaxLen) begin
               pend_chars[pend_len] = ch;
               pend_len++;
            end else begin
               pend_ovf = 1;
            end
         end
         CMD_END: close_word(r);
         CMD_READ: begin
            if (idx < n_used) begin
               if (pos < tbl_len[idx]) r.rd_char = tbl_chars[idx][pos];
               r.rd_len = tbl_len[idx][5:0];
               r.rd_count = tbl_cnt[idx][15:0];
               r.rd_sel = (tbl_cnt[idx] == key_val);
            end
         end
         default: n_used = 0;
      endcase
      r.used = n_used[8:0];
      return r;
   endfunction

   task automatic send_item(input logic [1:0] cmd, input logic [7:0] ch = 0,
                            input logic [7:0] idx = 0, input logic [4:0] pos = 0);
      if ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
         while ($urandom_range(99) < tx_idle_pct) @(posedge clock);
      end
      req_valid <= 1;
      req_cmd <= cmd;
      req_text_byte <= ch;
      req_entry_index <= idx;
      req_char_pos <= pos;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_results.push_back(predict_table(cmd, ch, idx, pos));
   endtask

   task automatic send_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++) send_item(CMD_BYTE, s[i]);
   endtask

   task automatic drain;
      req_valid <= 0;
      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_key(input logic [15:0] v);
      drain();
      csr_valid <= 1;
      csr_key_count <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 0;
      key_val = v;
   endtask

   task automatic check_field(input string name, input int exp_v, input int act_v);
      if (exp_v != act_v) begin
         $display("%0t mismatch %s: expected %0d actual %0d", $time, name, exp_v, act_v);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      word_result_t e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            $display("%0t unexpected result item", $time);
            errors++;
         end else begin
            e = expected_results.pop_front();
            check_field("word_done", e.done, rsp_word_done);
            check_field("word_new", e.is_new, rsp_word_new);
            check_field("word_slot", e.slot, rsp_word_slot);
            check_field("word_count", e.count, rsp_word_count);
            check_field("error_code", e.err, rsp_error_code);
            check_field("read_char", e.rd_char, rsp_read_char);
            check_field("read_len", e.rd_len, rsp_read_len);
            check_field("read_count", e.rd_count, rsp_read_count);
            check_field("read_selected", e.rd_sel, rsp_read_selected);
            check_field("entries_used", e.used, rsp_entries_used);
         end
      end
   end

   // receiver: random stall, or a long hold-off on request
   always @(posedge clock) begin
      if (hold_seen != hold_goal) begin
         hold_seen <= hold_goal;
         hold_left <= 400;
         rsp_stall <= 1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rx_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchLimit) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic test_directed;
      send_item(CMD_END);
      send_text("Hello  hELLO\n");
      send_text("[ {");
      send_item(CMD_BYTE, 8'h00);
      send_item(CMD_READ, 0, 0, 1);
      send_item(CMD_READ, 0, 0, 31);
      send_item(CMD_READ, 0, 2, 0);
      send_item(CMD_READ, 0, 255, 0);
      send_text("Zz");
      send_item(CMD_CLEAR);
      send_item(CMD_READ, 0, 0, 0);
      send_item(CMD_END);
      send_text("hello hello ");
      send_item(CMD_READ, 0, 1, 0);
   endtask

   task automatic test_long_words;
      int i;
      for (i = 0; i < 32; i++) send_item(CMD_BYTE, 8'hff - i[7:0]);
      send_item(CMD_BYTE, " ");
      for (i = 0; i < 33; i++) send_item(CMD_BYTE, 8'h80 | i[7:0]);
      send_item(CMD_END);
      send_item(CMD_READ, 0, 1, 31);
   endtask

   task automatic test_table_full;
      int i;
      int j;
      send_item(CMD_CLEAR);
      // one-byte words first, then two-byte words until one no longer fits
      for (i = 0; i < MaxWords + 1; i++) begin
         if (i < 128) begin
            send_item(CMD_BYTE, 8'h80 | i[7:0]);
         end else begin
            j = i - 128;
            send_item(CMD_BYTE, 8'h30 + {4'd0, j[3:0]});
            send_item(CMD_BYTE, 8'h30 + {4'd0, j[7:4]});
         end
         send_item(CMD_BYTE, " ");
      end
      send_text("Ba! ");
      send_item(CMD_READ, 0, 255, 2);
      send_item(CMD_READ, 0, 1, 0);
      send_item(CMD_CLEAR);
   endtask

   task automatic test_random(input int n);
      int sent;
      int kind;
      int wid;
      int wl;
      int j;
      logic [7:0] c;
      logic [7:0] seps [3];
      seps = '{" ", 8'h0a, 8'h00};
      sent = 0;
      while (sent < n) begin
         kind = $urandom_range(99);
         if (kind < 70) begin
            wid = $urandom_range(15);
            wl = 1 + wid % 5;
            for (j = 0; j < wl; j++) begin
               c = 8'h61 + 8'((wid * 7 + j * 3) % 26);
               if ($urandom_range(1)) c = c - 8'd32;
               send_item(CMD_BYTE, c);
            end
            if ($urandom_range(9) == 0) send_item(CMD_END);
            else send_item(CMD_BYTE, seps[$urandom_range(2)]);
            sent += wl + 1;
         end else if (kind < 80) begin
            send_item(CMD_BYTE, 8'($urandom_range(255)));
            sent++;
         end else if (kind < 82) begin
            wl = $urandom_range(30, 34);
            for (j = 0; j < wl; j++) send_item(CMD_BYTE, 8'($urandom_range(33, 255)));
            send_item(CMD_END);
            sent += wl + 1;
         end else if (kind < 97) begin
            if ($urandom_range(3) == 0) send_item(CMD_READ, 0, 8'($urandom_range(255)),
                                                  5'($urandom_range(31)));
            else send_item(CMD_READ, 0, 8'($urandom_range(n_used + 1)),
                           5'($urandom_range(31)));
            sent++;
         end else if (kind < 99) begin
            send_item(CMD_END);
            sent++;
         end else begin
            send_item(CMD_CLEAR);
            sent++;
         end
      end
   endtask

   initial begin
      n_used = 0;
      pend_len = 0;
      pend_ovf = 0;
      key_val = 3;
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      tx_idle_pct = 24;
      rx_idle_pct = 83;
      test_directed();
      test_long_words();
      write_key(16'd1);
      test_table_full();
      test_random(160);
      write_key(16'd2);
      tx_idle_pct = 83;
      rx_idle_pct = 24;
      test_random(160);
      write_key(16'($urandom_range(1, 65535)));
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      hold_goal = hold_goal + 1;
      test_random(170);
      drain();

      if (errors == 0 && expected_results.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule

/* filelist.f */
hw/rtl/wft_pkg.sv
hw/rtl/word_frequency_table.sv
dv/testbench.sv
